### hw/rtl/drpc_pkg.sv
package drpc_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int AHEAD     = 4;
	localparam int PAGE_BITS = 16;

	localparam logic [2:0] KIND_LOOKUP         = 3'd0;
	localparam logic [2:0] KIND_DEMAND_STORE   = 3'd1;
	localparam logic [2:0] KIND_PREFETCH_STORE = 3'd2;
	localparam logic [2:0] KIND_SET_POS        = 3'd3;
	localparam logic [2:0] KIND_PREFETCH_QUERY = 3'd4;
	localparam logic [2:0] KIND_CLEAR          = 3'd5;

	typedef struct packed {
		logic [2:0]           kind;
		logic [PAGE_BITS-1:0] page_index;
		logic [31:0]          page_size;
		logic [31:0]          payload_handle;
	} req_t;

	typedef struct packed {
		logic                 out_of_range;
		logic                 hit;
		logic [2:0]           slot_number;
		logic [31:0]          found_size;
		logic [31:0]          found_handle;
		logic                 stored;
		logic                 evicted_valid;
		logic [PAGE_BITS-1:0] evicted_page;
		logic                 target_valid;
		logic [PAGE_BITS-1:0] target_page;
	} rsp_t;

	typedef struct packed {
		logic [PAGE_BITS-1:0] page;
		logic [31:0]          size;
		logic [31:0]          handle;
	} slot_entry_t;

endpackage

### hw/rtl/drpc_ram.sv
module drpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/distance_replacement_page_cache_core.sv
// Page-slot directory with distance-based replacement. Slot contents (page, size, handle)
// live in a single-port-read RAM; valid bits and the reading position sit in flops.
// Lookups, stores and prefetch queries walk the RAM one slot per cycle in the scan state,
// then pass the last and resolve states; set position, clear, out-of-range requests
// and unused kinds go straight to resolve. The response register frees the input side:
// a new request is taken while the previous response still waits. page_count must be
// written only while the block is idle; the block itself does not enforce this.
module distance_replacement_page_cache_core
	import drpc_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [PAGE_BITS-1:0] cfg_wdata
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int EW = $bits(slot_entry_t);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_LAST, ST_RESOLVE} state_t;

	state_t               state_q;
	req_t                 req_q;
	logic [PAGE_BITS-1:0] page_count_q;
	logic [PAGE_BITS-1:0] pos_q;
	logic [SLOTS-1:0]     slot_valid_q;
	logic [SW-1:0]        scan_idx_q;
	logic                 rd_vld_s1;
	logic [SW-1:0]        rd_slot_s1;
	logic                 match_q;
	logic [SW-1:0]        match_slot_q;
	logic [31:0]          match_size_q;
	logic [31:0]          match_handle_q;
	logic                 have_q;
	logic [PAGE_BITS-1:0] best_dist_q;
	logic [SW-1:0]        best_slot_q;
	logic [PAGE_BITS-1:0] best_page_q;
	logic [AHEAD-1:0]     cached_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	slot_entry_t          rd_entry;
	slot_entry_t          wr_entry;
	logic [EW-1:0]        rd_bits;
	logic                 ram_we;
	logic [SW-1:0]        victim;
	logic                 scan_hit;
	logic                 rd_match;
	logic [PAGE_BITS-1:0] rd_dist;
	logic [PAGE_BITS:0]   rd_diff;
	logic [AHEAD-1:0]     ahead_hit;
	logic                 have_free;
	logic [SW-1:0]        free_idx;
	logic                 rsp_ld;
	logic                 req_oor;
	logic                 store_go;
	rsp_t                 res;

	function automatic logic [PAGE_BITS-1:0] abs_diff(input logic [PAGE_BITS-1:0] a,
		input logic [PAGE_BITS-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic logic [2:0] slot_field(input logic [SW-1:0] s);
		return 3'(32'(s));
	endfunction

	assign wr_entry = '{page: req_q.page_index, size: req_q.page_size,
		handle: req_q.payload_handle};
	assign rd_entry = slot_entry_t'(rd_bits);

	drpc_ram #(
		.WIDTH(EW),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(victim),
		.wdata(EW'(wr_entry)),
		.re   (state_q == ST_SCAN),
		.raddr(scan_idx_q),
		.rdata(rd_bits)
	);

	// per-slot evaluation of the entry read in the previous cycle
	assign scan_hit = rd_vld_s1 && slot_valid_q[rd_slot_s1];
	assign rd_match = rd_entry.page == req_q.page_index;
	assign rd_dist  = abs_diff(rd_entry.page, pos_q);
	assign rd_diff  = {1'b0, rd_entry.page} - {1'b0, pos_q};

	always_comb begin
		for (int j = 0; j < AHEAD; j++) begin
			ahead_hit[j] = scan_hit && (rd_entry.page > pos_q) &&
				(rd_diff == (PAGE_BITS+1)'(j + 1));
		end
	end

	// lowest empty slot
	always_comb begin
		have_free = 1'b0;
		free_idx  = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!slot_valid_q[i]) begin
				have_free = 1'b1;
				free_idx  = SW'(i);
			end
		end
	end

	assign victim  = have_free ? free_idx : best_slot_q;
	assign req_oor = req_q.page_index >= page_count_q;
	assign rsp_ld  = (state_q == ST_RESOLVE) && (!rsp_valid_q || !rsp_stall);
	assign ram_we  = rsp_ld && store_go;

	always_comb begin
		logic [PAGE_BITS:0] idx;
		logic               done;
		res      = '0;
		store_go = 1'b0;
		idx      = '0;
		done     = 1'b0;
		case (req_q.kind)
			KIND_LOOKUP: begin
				if (req_oor) begin
					res.out_of_range = 1'b1;
				end else if (match_q) begin
					res.hit          = 1'b1;
					res.slot_number  = slot_field(match_slot_q);
					res.found_size   = match_size_q;
					res.found_handle = match_handle_q;
				end
			end
			KIND_DEMAND_STORE, KIND_PREFETCH_STORE: begin
				if (req_oor) begin
					res.out_of_range = 1'b1;
				end else if (req_q.page_size != '0 && !match_q &&
					!(req_q.kind == KIND_PREFETCH_STORE &&
					abs_diff(req_q.page_index, pos_q) > PAGE_BITS'(AHEAD + 2))) begin
					store_go          = 1'b1;
					res.stored        = 1'b1;
					res.slot_number   = slot_field(victim);
					res.evicted_valid = !have_free;
					res.evicted_page  = have_free ? '0 : best_page_q;
				end
			end
			KIND_PREFETCH_QUERY: begin
				for (int i = 1; i <= AHEAD; i++) begin
					idx = {1'b0, pos_q} + (PAGE_BITS+1)'(i);
					if (!done) begin
						if (idx >= {1'b0, page_count_q}) begin
							done = 1'b1;
						end else if (!cached_q[i-1]) begin
							done             = 1'b1;
							res.target_valid = 1'b1;
							res.target_page  = idx[PAGE_BITS-1:0];
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			page_count_q <= '0;
			pos_q        <= '0;
			slot_valid_q <= '0;
			scan_idx_q   <= '0;
			rd_vld_s1    <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				page_count_q <= cfg_wdata;
			end
			if (rsp_valid_q && !rsp_stall && !rsp_ld) begin
				rsp_valid_q <= 1'b0;
			end

			if (scan_hit) begin
				if (rd_match && !match_q) begin
					match_q        <= 1'b1;
					match_slot_q   <= rd_slot_s1;
					match_size_q   <= rd_entry.size;
					match_handle_q <= rd_entry.handle;
				end
				if (!have_q || rd_dist > best_dist_q) begin
					have_q      <= 1'b1;
					best_dist_q <= rd_dist;
					best_slot_q <= rd_slot_s1;
					best_page_q <= rd_entry.page;
				end
				cached_q <= cached_q | ahead_hit;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						req_q      <= req;
						match_q    <= 1'b0;
						have_q     <= 1'b0;
						cached_q   <= '0;
						scan_idx_q <= '0;
						rd_vld_s1  <= 1'b0;
						if (req.kind == KIND_PREFETCH_QUERY ||
							((req.kind == KIND_LOOKUP || req.kind == KIND_DEMAND_STORE ||
							req.kind == KIND_PREFETCH_STORE) &&
							req.page_index < page_count_q)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_RESOLVE;
						end
					end
				end
				ST_SCAN: begin
					rd_vld_s1  <= 1'b1;
					rd_slot_s1 <= scan_idx_q;
					if (scan_idx_q == SW'(SLOTS - 1)) begin
						state_q <= ST_LAST;
					end else begin
						scan_idx_q <= scan_idx_q + SW'(1);
					end
				end
				ST_LAST: begin
					rd_vld_s1 <= 1'b0;
					state_q   <= ST_RESOLVE;
				end
				ST_RESOLVE: begin
					if (rsp_ld) begin
						rsp_q       <= res;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (store_go) begin
							slot_valid_q[victim] <= 1'b1;
						end
						if (req_q.kind == KIND_SET_POS) begin
							pos_q <= req_q.page_index;
						end
						if (req_q.kind == KIND_CLEAR) begin
							slot_valid_q <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_we_only_on_store: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> rsp_ld && (req_q.kind == KIND_DEMAND_STORE ||
		req_q.kind == KIND_PREFETCH_STORE))
		else $error("slot RAM written outside a store response");

	a_evict_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ld && res.evicted_valid |-> &slot_valid_q)
		else $error("eviction reported while an empty slot exists");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ld && req_q.kind == KIND_CLEAR |=> slot_valid_q == '0)
		else $error("clear request left valid slots");

endmodule
